FILE: src/ffg_pkg.sv
// Package for the first-fit gap finder: widths, request/result structs,
// lane result struct and field extraction helpers. No dependencies.
package ffg_pkg;

	// Number of occupied regions that take part (2 to 5)
	localparam int REGION_COUNT = 5;
	localparam int RANK_W       = $clog2(REGION_COUNT);

	localparam int START_W = 27;
	localparam int LEN_W   = 28;
	localparam int SIZE_W  = 28;
	localparam int LIMIT_W = 28;
	localparam int END_W   = 29;
	localparam int SUM_W   = 30;

	localparam logic [LIMIT_W-1:0] ADDR_SPACE_MAX = 28'd134217728;

	typedef logic [START_W-1:0] start_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [SIZE_W-1:0]  size_t;
	typedef logic [LIMIT_W-1:0] limit_t;
	typedef logic [END_W-1:0]   end_t;
	typedef logic [RANK_W-1:0]  rank_t;

	typedef struct packed {
		size_t  request_size;
		start_t start_a;
		len_t   length_a;
		start_t start_b;
		len_t   length_b;
		start_t start_c;
		len_t   length_c;
		start_t start_d;
		len_t   length_d;
		start_t start_e;
		len_t   length_e;
	} in_item_t;

	typedef struct packed {
		logic   found;
		start_t place_address;
	} out_item_t;

	// What one fit lane reports to the merge stage
	typedef struct packed {
		logic   fit;
		start_t place;
	} lane_result_t;

	// Start address of region idx in the request
	function automatic start_t item_start(in_item_t it, int idx);
		start_t s;
		case (idx)
			0:       s = it.start_a;
			1:       s = it.start_b;
			2:       s = it.start_c;
			3:       s = it.start_d;
			default: s = it.start_e;
		endcase
		return s;
	endfunction

	// Length of region idx in the request
	function automatic len_t item_length(in_item_t it, int idx);
		len_t l;
		case (idx)
			0:       l = it.length_a;
			1:       l = it.length_b;
			2:       l = it.length_c;
			3:       l = it.length_d;
			default: l = it.length_e;
		endcase
		return l;
	endfunction

endpackage

FILE: src/ffg_rank_lane.sv
// Rank lane: position of one region in a stable ascending sort by start.
// Depends on ffg_pkg.
module ffg_rank_lane (
	input  ffg_pkg::start_t                         own_start,
	input  ffg_pkg::start_t                         starts [ffg_pkg::REGION_COUNT],
	input  logic [ffg_pkg::REGION_COUNT-1:0]        earlier,
	output ffg_pkg::rank_t                          rank
);
	import ffg_pkg::*;

	logic [REGION_COUNT-1:0] lower;

	// Flag regions that sort ahead: smaller start, or equal start and earlier in input
	always_comb begin
		for (int j = 0; j < REGION_COUNT; j++) begin
			lower[j] = (starts[j] < own_start) ||
				((starts[j] == own_start) && earlier[j]);
		end
	end

	// Count them
	always_comb begin
		rank = '0;
		for (int j = 0; j < REGION_COUNT; j++) begin
			rank = rank + RANK_W'(lower[j]);
		end
	end

endmodule

FILE: src/ffg_fit_lane.sv
// Fit lane: checks whether the request fits between the end of one sorted
// region and its bound (next start or memory limit). Depends on ffg_pkg.
module ffg_fit_lane (
	input  ffg_pkg::end_t         region_end,
	input  ffg_pkg::size_t        size,
	input  ffg_pkg::limit_t       bound,
	output ffg_pkg::lane_result_t result
);
	import ffg_pkg::*;

	logic [SUM_W-1:0] need;

	// Wide sum so the compare never wraps
	assign need = SUM_W'(region_end) + SUM_W'(size);
	assign result.fit   = (need <= SUM_W'(bound));
	assign result.place = region_end[START_W-1:0];

endmodule

FILE: src/ffg_merge.sv
// Merge stage: picks the first fitting place, head gap before all lanes,
// then lanes in sorted order. Depends on ffg_pkg.
module ffg_merge (
	input  logic                  head_fit,
	input  ffg_pkg::lane_result_t lanes [ffg_pkg::REGION_COUNT],
	output ffg_pkg::out_item_t    result
);
	import ffg_pkg::*;

	// Walk from the last lane down so the lowest fitting lane wins
	always_comb begin
		result.found         = 1'b0;
		result.place_address = '0;
		for (int i = REGION_COUNT - 1; i >= 0; i--) begin
			if (lanes[i].fit) begin
				result.found         = 1'b1;
				result.place_address = lanes[i].place;
			end
		end
		if (head_fit) begin
			result.found         = 1'b1;
			result.place_address = '0;
		end
	end

endmodule

FILE: src/first_fit_gap_finder.sv
// Top level of the first-fit gap finder: rank, sort and fit stages.
// Depends on ffg_pkg, ffg_rank_lane, ffg_fit_lane and ffg_merge.

// Finds the first address where a request of request_size bytes fits among
// REGION_COUNT occupied regions: before the lowest region, in a gap between
// neighbors sorted by start (equal starts keep input order), or after the last
// region up to memory_limit (clamped to 2^27). A request is accepted every
// cycle while in_ready is high; its result appears on a registered
// output. The three stages are: one rank lane per region (parallel compares),
// the sort mux with end-address adders, and one fit lane per gap with a
// priority merge. Back-pressure stalls the pipeline only where a stage is full.
// memory_limit is written through cfg_valid/cfg_data, which is always ready.
module first_fit_gap_finder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ffg_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ffg_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  ffg_pkg::limit_t    cfg_data
);
	import ffg_pkg::*;

	// Configuration
	limit_t limit_q;

	// Stage 1: raw regions with ranks
	logic   v_s1;
	size_t  req_s1;
	start_t starts_s1 [REGION_COUNT];
	len_t   lens_s1   [REGION_COUNT];
	rank_t  ranks_s1  [REGION_COUNT];

	// Stage 2: sorted regions with end addresses
	logic   v_s2;
	size_t  req_s2;
	start_t starts_s2 [REGION_COUNT];
	end_t   ends_s2   [REGION_COUNT];

	// Output register
	logic      out_valid_q;
	out_item_t out_item_q;

	// Stage loads
	logic ld1, ld2, ld3;

	start_t                  in_starts [REGION_COUNT];
	len_t                    in_lens   [REGION_COUNT];
	logic [REGION_COUNT-1:0] earlier   [REGION_COUNT];
	rank_t                   in_ranks  [REGION_COUNT];
	logic [REGION_COUNT-1:0] slot_sel  [REGION_COUNT];
	start_t                  sort_start [REGION_COUNT];
	end_t                    sort_end   [REGION_COUNT];
	lane_result_t            lanes     [REGION_COUNT];
	logic                    head_fit;
	out_item_t               merged;

	// Hold a stage while the one after it is full and stalled
	assign ld3      = out_ready || !out_valid_q;
	assign ld2      = ld3 || !v_s2;
	assign ld1      = ld2 || !v_s1;
	assign in_ready = ld1;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign cfg_ready = 1'b1;

	// Store the limit already clamped to the address space
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ADDR_SPACE_MAX;
		end else if (cfg_valid) begin
			limit_q <= (cfg_data > ADDR_SPACE_MAX) ? ADDR_SPACE_MAX : cfg_data;
		end
	end

	// Rank each region of the incoming request
	for (genvar g = 0; g < REGION_COUNT; g++) begin : g_rank
		assign in_starts[g] = item_start(in_item, g);
		assign in_lens[g]   = item_length(in_item, g);
		assign earlier[g]   = ~({REGION_COUNT{1'b1}} << g);

		ffg_rank_lane u_rank (
			.own_start (in_starts[g]),
			.starts    (in_starts),
			.earlier   (earlier[g]),
			.rank      (in_ranks[g])
		);
	end

	// Sort mux: slot k takes the region whose rank is k, and its end address
	always_comb begin
		for (int k = 0; k < REGION_COUNT; k++) begin
			sort_start[k] = '0;
			sort_end[k]   = '0;
			for (int i = 0; i < REGION_COUNT; i++) begin
				slot_sel[k][i] = (ranks_s1[i] == RANK_W'(k));
				if (slot_sel[k][i]) begin
					sort_start[k] = sort_start[k] | starts_s1[i];
					sort_end[k]   = sort_end[k] |
						(END_W'(starts_s1[i]) + END_W'(lens_s1[i]));
				end
			end
		end
	end

	// Fit lanes: gap after each sorted region, the last bounded by the limit
	for (genvar g = 0; g < REGION_COUNT; g++) begin : g_fit
		limit_t bound;
		if (g < REGION_COUNT - 1) begin : g_gap
			assign bound = LIMIT_W'(starts_s2[g+1]);
		end else begin : g_tail
			assign bound = limit_q;
		end

		ffg_fit_lane u_fit (
			.region_end (ends_s2[g]),
			.size       (req_s2),
			.bound      (bound),
			.result     (lanes[g])
		);
	end

	assign head_fit = (LIMIT_W'(starts_s2[0]) >= req_s2);

	ffg_merge u_merge (
		.head_fit (head_fit),
		.lanes    (lanes),
		.result   (merged)
	);

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) out_valid_q <= v_s2;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			req_s1    <= in_item.request_size;
			starts_s1 <= in_starts;
			lens_s1   <= in_lens;
			ranks_s1  <= in_ranks;
		end
		if (ld2 && v_s1) begin
			req_s2    <= req_s1;
			starts_s2 <= sort_start;
			ends_s2   <= sort_end;
		end
		if (ld3 && v_s2) begin
			out_item_q <= merged;
		end
	end

`ifndef SYNTHESIS
	// An accepted request always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request missing from stage 1");

	// No result claims an address without a fit
	a_no_fit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.found |-> out_item.place_address == '0)
		else $error("place_address nonzero without a fit");

	for (genvar k = 0; k < REGION_COUNT; k++) begin : g_chk
		// Ranks form a permutation: each slot picks exactly one region
		a_slot_onehot: assert property (@(posedge clk) disable iff (!arst_n)
			v_s1 |-> $onehot(slot_sel[k]))
			else $error("sort slot not selected exactly once");

		if (k < REGION_COUNT - 1) begin : g_ord
			// Sorted starts never decrease
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				v_s2 |-> starts_s2[k] <= starts_s2[k+1])
				else $error("sorted starts out of order");
		end
	end
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for first_fit_gap_finder: directed table, then random requests
// under several memory limits, scored by table rows or an in-bench first-fit predictor.
// Depends on ffg_pkg and the first_fit_gap_finder RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ffg_pkg::*;

	localparam int     PIPE_DEPTH     = 3;
	localparam int     SETTLE_CYCLES  = PIPE_DEPTH + 4;
	localparam int     WATCHDOG_LIMIT = 1000;
	localparam int     PHASE_ITEMS    = 290;
	localparam int     REPORT_MAX     = 10;
	localparam start_t TOP_START      = 27'h7FFFFFF;
	localparam len_t   TOP_LEN        = ADDR_SPACE_MAX;
	localparam bit     TYPED          = 1'b1;
	localparam bit     PREDICT        = 1'b0;

	typedef struct {
		in_item_t  req;
		bit        typed;
		out_item_t result;
	} directed_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	limit_t    cfg_data = '0;

	out_item_t     placements_due[$];
	directed_row_t directed_rows[$];
	limit_t        active_limit = ADDR_SPACE_MAX;
	int            failures = 0;
	bit            gaps_on = 1'b1;
	int            gap_rate = 0;
	int            stall_rate = 0;
	int            stall_left = 0;
	int            cycle_count = 0;
	int            quiet_cycles = 0;

	first_fit_gap_finder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// First-fit placement: stable sort by start, then scan before/between/after
	function automatic out_item_t first_fit(in_item_t req, limit_t lim);
		longint unsigned st[5];
		longint unsigned ln[5];
		longint unsigned s, l, tail, cap;
		int n, j;
		out_item_t res;
		st[0] = req.start_a; ln[0] = req.length_a;
		st[1] = req.start_b; ln[1] = req.length_b;
		st[2] = req.start_c; ln[2] = req.length_c;
		st[3] = req.start_d; ln[3] = req.length_d;
		st[4] = req.start_e; ln[4] = req.length_e;
		n = REGION_COUNT;
		// insertion sort keeps equal starts in input order
		for (int i = 1; i < n; i++) begin
			s = st[i];
			l = ln[i];
			j = i;
			while (j > 0 && st[j-1] > s) begin
				st[j] = st[j-1];
				ln[j] = ln[j-1];
				j--;
			end
			st[j] = s;
			ln[j] = l;
		end
		cap = (lim > ADDR_SPACE_MAX) ? ADDR_SPACE_MAX : lim;
		res = '0;
		for (int i = 0; i < n && !res.found; i++) begin
			tail = st[i] + ln[i];
			if (i == 0 && st[0] >= req.request_size) begin
				res.found = 1'b1;
				res.place_address = '0;
			end else if (i < n - 1 && tail + req.request_size <= st[i+1]) begin
				res.found = 1'b1;
				res.place_address = start_t'(tail);
			end else if (i == n - 1 && tail + req.request_size <= cap) begin
				res.found = 1'b1;
				res.place_address = start_t'(tail);
			end
		end
		return res;
	endfunction

	// Zero, the top of the range, or anything in between
	function automatic longint pick_edge(longint top);
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return top;
			default: return longint'($urandom_range(0, top));
		endcase
	endfunction

	// Mostly laid-out regions with a size aimed at one gap; the rest noise and extremes
	function automatic in_item_t random_request(limit_t lim);
		in_item_t it;
		longint st[5];
		longint ln[5];
		longint span, cursor, room, cap, sz, t;
		int pick, k, m;
		pick = $urandom_range(0, 9);
		cap = (lim > ADDR_SPACE_MAX) ? longint'(ADDR_SPACE_MAX) : longint'(lim);
		if (pick < 6) begin
			span = ($urandom_range(0, 3) == 0) ? 134217727 : longint'($urandom_range(8, 4096));
			cursor = ($urandom_range(0, 2) == 0) ? 0 : longint'($urandom_range(0, span / 8));
			for (int i = 0; i < 5; i++) begin
				st[i] = cursor;
				ln[i] = $urandom_range(0, span / 8);
				cursor += ln[i];
				if ($urandom_range(0, 2) != 0)
					cursor += $urandom_range(0, span / 8);
				if (cursor > 134217727)
					cursor = 134217727;
			end
			// aim the size at one spot, give or take one byte
			k = $urandom_range(0, 5);
			if (k == 0)
				room = st[0];
			else if (k < 5)
				room = st[k] - (st[k-1] + ln[k-1]);
			else
				room = cap - (st[4] + ln[4]);
			sz = room + $urandom_range(0, 2) - 1;
			if (sz < 0)
				sz = 0;
			if (sz > 134217728)
				sz = 134217728;
			if ($urandom_range(0, 4) == 0)
				st[1] = st[0];
			// shuffle region order
			for (int i = 4; i > 0; i--) begin
				m = $urandom_range(0, i);
				t = st[i]; st[i] = st[m]; st[m] = t;
				t = ln[i]; ln[i] = ln[m]; ln[m] = t;
			end
		end else if (pick < 8) begin
			for (int i = 0; i < 5; i++) begin
				st[i] = $urandom_range(0, 134217727);
				ln[i] = $urandom_range(0, 134217728);
			end
			sz = $urandom_range(0, 134217728);
		end else begin
			for (int i = 0; i < 5; i++) begin
				st[i] = pick_edge(134217727);
				ln[i] = pick_edge(134217728);
			end
			sz = pick_edge(134217728);
		end
		it.request_size = size_t'(sz);
		it.start_a = start_t'(st[0]); it.length_a = len_t'(ln[0]);
		it.start_b = start_t'(st[1]); it.length_b = len_t'(ln[1]);
		it.start_c = start_t'(st[2]); it.length_c = len_t'(ln[2]);
		it.start_d = start_t'(st[3]); it.length_d = len_t'(ln[3]);
		it.start_e = start_t'(st[4]); it.length_e = len_t'(ln[4]);
		return it;
	endfunction

	function automatic void add_row(size_t sz, start_t sa, len_t la, start_t sb, len_t lb,
			start_t sc, len_t lc, start_t sd, len_t ld, start_t se, len_t le,
			bit typed, logic found, start_t place);
		directed_row_t row;
		row.req = '{sz, sa, la, sb, lb, sc, lc, sd, ld, se, le};
		row.typed = typed;
		row.result.found = found;
		row.result.place_address = place;
		directed_rows.push_back(row);
	endfunction

	function automatic void note_failure(string msg);
		failures++;
		if (failures <= REPORT_MAX)
			$display("[%0t] mismatch: %s", $time, msg);
	endfunction

	// Hold the request until accepted, then queue its placement
	task automatic push_request(in_item_t req, out_item_t want);
		in_valid <= 1'b1;
		in_item <= req;
		do @(posedge clk); while (!in_ready);
		placements_due.push_back(want);
	endtask

	// Drop valid for a short burst now and then
	task automatic maybe_pause();
		if (gaps_on && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Wait out every placement, then let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		while (placements_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(limit_t value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		active_limit = value;
		cfg_valid <= 1'b0;
	endtask

	// Score accepted results and stall the result side in bursts
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (placements_due.size() == 0) begin
				note_failure($sformatf("unexpected result found=%0b place=%0d",
					out_item.found, out_item.place_address));
			end else begin
				want = placements_due.pop_front();
				if (out_item.found !== want.found ||
						out_item.place_address !== want.place_address)
					note_failure($sformatf("expected found=%0b place=%0d, got found=%0b place=%0d",
						want.found, want.place_address, out_item.found,
						out_item.place_address));
			end
		end
		cycle_count++;
		if (cycle_count % 64 == 0)
			stall_rate = ($urandom_range(0, 2) == 0) ? 0 : (2 << $urandom_range(0, 2));
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (gaps_on && stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
			stall_left = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		limit_t phase_limits[6];
		out_item_t want;
		phase_limits[0] = 28'd1;
		phase_limits[1] = 28'd0;
		phase_limits[2] = 28'hFFFFFFF;
		phase_limits[3] = limit_t'($urandom_range(2, 134217727));
		phase_limits[4] = 28'd4096;
		phase_limits[5] = ADDR_SPACE_MAX;

		// zero-size requests always land at address 0
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, TYPED, 1'b1, 0);
		add_row(0, TOP_START, TOP_LEN, TOP_START, TOP_LEN, TOP_START, TOP_LEN,
			TOP_START, TOP_LEN, TOP_START, TOP_LEN, TYPED, 1'b1, 0);
		// largest size: fits only in a fully empty space
		add_row(TOP_LEN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, TYPED, 1'b1, 0);
		add_row(TOP_LEN, TOP_START, TOP_LEN, TOP_START, TOP_LEN, TOP_START, TOP_LEN,
			TOP_START, TOP_LEN, TOP_START, TOP_LEN, TYPED, 1'b0, 0);
		add_row(TOP_LEN, TOP_START, 0, TOP_START, 0, TOP_START, 0, TOP_START, 0,
			TOP_START, 0, TYPED, 1'b0, 0);
		// room before the lowest region
		add_row(1, TOP_START, 0, TOP_START, 0, TOP_START, 0, TOP_START, 0,
			TOP_START, 0, TYPED, 1'b1, 0);
		add_row(28'h7FFFFFF, TOP_START, 0, TOP_START, 0, TOP_START, 0, TOP_START, 0,
			TOP_START, 0, TYPED, 1'b1, 0);
		// whole space taken by huge regions
		add_row(1, 0, TOP_LEN, 0, TOP_LEN, 0, TOP_LEN, 0, TOP_LEN, 0, TOP_LEN, TYPED, 1'b0, 0);
		// tail fit exactly at the limit, then one byte over
		add_row(size_t'(TOP_LEN - 28'd50), 0, 10, 10, 10, 20, 10, 30, 10, 40, 10,
			TYPED, 1'b1, 50);
		add_row(size_t'(TOP_LEN - 28'd49), 0, 10, 10, 10, 20, 10, 30, 10, 40, 10,
			TYPED, 1'b0, 0);
		// exact gap fit, then one byte too big for the gap
		add_row(10, 0, 10, 10, 10, 30, 10, 40, 10, 50, 10, TYPED, 1'b1, 20);
		add_row(11, 0, 10, 10, 10, 30, 10, 40, 10, 50, 10, TYPED, 1'b1, 60);
		// regions given out of order
		add_row(50, 500, 100, 100, 100, 300, 100, 200, 50, 0, 100, PREDICT, 1'b0, 0);
		// equal starts keep input order
		add_row(20, 100, 5, 100, 50, 0, 100, 400, 10, 1000, 10, PREDICT, 1'b0, 0);
		add_row(20, 100, 50, 100, 5, 0, 100, 400, 10, 1000, 10, PREDICT, 1'b0, 0);
		// overlapping regions: gaps only between sorted neighbors
		add_row(5, 0, 1000, 10, 5, 20, 5, 2000, 0, 3000, 0, PREDICT, 1'b0, 0);
		// alternating bit patterns
		add_row(28'h5555555, 27'h5555555, 28'hAAAAAA, 27'h2AAAAAA, 28'h5555555,
			27'h1234567, 28'h0, 27'h0, 28'h8000000, 27'h7FFFFFF, 28'h1, PREDICT, 1'b0, 0);

		// hold reset, then release on a clock edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset limit
		gap_rate = 3;
		foreach (directed_rows[i]) begin
			want = directed_rows[i].typed ? directed_rows[i].result
				: first_fit(directed_rows[i].req, active_limit);
			maybe_pause();
			push_request(directed_rows[i].req, want);
		end
		drain();

		// random phases, one memory limit each; no idling in the last one
		foreach (phase_limits[p]) begin
			write_limit(phase_limits[p]);
			gaps_on = (p != 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				in_item_t req;
				if (n % 50 == 0)
					gap_rate = ($urandom_range(0, 2) == 0) ? 0 : (2 << $urandom_range(0, 2));
				req = random_request(active_limit);
				maybe_pause();
				push_request(req, first_fit(req, active_limit));
			end
			drain();
		end

		if (failures == 0 && placements_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
